>>> rtl/core/tds_conversion_with_moving_average_top_defines.svh
// ----------------------------------------------------------------------------
// TDS conversion assertion macros
// Shared concurrent assertion forms for the TDS conversion core.
// ----------------------------------------------------------------------------
`ifndef TDS_CONVERSION_WITH_MOVING_AVERAGE_TOP_DEFINES_SVH
`define TDS_CONVERSION_WITH_MOVING_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define TDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tds_pkg.sv
// ----------------------------------------------------------------------------
// TDS conversion package
// Constants, codes, sequencer states and unit request types.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int FILTER_DEPTH = 8;
  localparam int PTR_W        = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int OUT_W        = 24;
  localparam int SUM_W        = OUT_W + PTR_W;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 41;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [OUT_W-1:0]     GAIN_RESET  = 24'd32768;
  localparam logic [OUT_W-1:0]     OUT_MAX     = 24'hFFFFFF;
  localparam logic [20:0]          V_MAX       = 21'd2097151;
  localparam logic [MUL_B_W-1:0]   COEF3       = 32'd8743854;
  localparam logic [MUL_B_W-1:0]   COEF2       = 32'd16768041;
  localparam logic [MUL_B_W-1:0]   COEF1       = 32'd56189911;
  localparam logic [MUL_B_W-1:0]   MV_PER_V    = 32'd1000;
  localparam logic [MUL_B_W-1:0]   CENTI       = 32'd100;
  // ceil(2^37 / 100): floor(x / 100) is (x * CENTI_RECIP) >> 37 for x below 2^32
  localparam logic [MUL_B_W-1:0]   CENTI_RECIP = 32'd1374389535;

  localparam logic [12:0] RST_REF_MV  = 13'd5000;
  localparam logic [15:0] RST_FS      = 16'd1023;
  localparam logic [15:0] RST_TDS_F   = 16'd42598;
  localparam logic [15:0] RST_TEMP_K  = 16'd1311;

  typedef enum logic [2:0] {
    REG_REF_MV  = 3'd0,
    REG_FS      = 3'd1,
    REG_TDS_F   = 3'd2,
    REG_TEMP_K  = 3'd3,
    REG_FILT_EN = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_CAL     = 2'd1,
    CMD_RESET   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_MEASURED   = 3'd0,
    STS_SATURATED  = 3'd1,
    STS_CALIBRATED = 3'd2,
    STS_CAL_FAIL   = 3'd3,
    STS_GAIN_RESET = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NUM, ST_DEN, ST_V, ST_V2, ST_V3, ST_T3, ST_T2, ST_T1, ST_KD,
    ST_C, ST_EC, ST_ECC, ST_FB, ST_RAW, ST_RING, ST_RAWEC, ST_RC, ST_G, ST_FIN
  } state_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] data;
  } ring_req_t;

endpackage

>>> rtl/core/tds_conversion_with_moving_average_top.sv
// ----------------------------------------------------------------------------
// TDS conversion with moving average, top level
// Measure or calibrate: one word at a time; the work is set by the bit-serial
// multiplier (one bit per cycle, stops after the top set bit of the multiplier)
// and the 64-step divider. Gain reset and the unused command go straight to
// the output step; output stalls hold it there. Synchronous reset restores the
// registers and gain 0.5 and clears the ring valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`include "tds_conversion_with_moving_average_top_defines.svh"

module tds_conversion_with_moving_average_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [11:0]        in_adc_sample,
  input  logic signed [14:0] in_temperature_centideg,
  input  logic [14:0]        in_reference_ppm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_tds_centippm,
  output logic [23:0]        out_probe_gain_q16,
  output logic [2:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  tds_pkg::state_t  state_r, state_nxt;
  tds_pkg::cmd_t    cmd_r;
  tds_pkg::status_t status_r;
  tds_pkg::mul_req_t  mul_req;
  tds_pkg::div_req_t  div_req;
  tds_pkg::ring_req_t ring_req;

  logic                          mul_done, div_done, ring_done;
  logic [tds_pkg::MUL_P_W-1:0]   mul_prod;
  logic [tds_pkg::DIV_NUM_W-1:0] div_q;
  logic [23:0]                   ring_mean;

  logic [12:0] ref_r;
  logic [15:0] fs_r, f_r, k_r;
  logic        filt_r;
  logic [15:0] fs_eff;
  logic [23:0] gain_r;
  logic        wait_r;
  logic        out_valid_r;
  logic [23:0] out_tds_r, out_gain_r;
  logic [2:0]  out_status_r;

  logic [11:0]        code_r;
  logic signed [14:0] temp_r;
  logic [14:0]        ppm_r;
  logic [24:0]        num_r;
  logic [25:0]        den_r;
  logic [20:0]        v_r;
  logic [25:0]        v2_r;
  logic [30:0]        v3_r;
  logic signed [63:0] acc_r, acc_sum, prod64;
  logic [39:0]        poly_r;
  logic [30:0]        kd_r;
  logic               neg_r;
  logic [25:0]        comp_r, comp_nxt;
  logic signed [26:0] comp_s;
  logic [26:0]        qx;
  logic [47:0]        ec_r;
  logic [63:0]        ecc_r;
  logic [22:0]        fb_r;
  logic [23:0]        raw_r;
  logic [46:0]        rawec_r;
  logic [46:0]        rc_r;
  logic               rc_big, raw_big, cal_fail;
  logic signed [15:0] tdiff, tneg;
  logic [14:0]        tabs;
  logic               in_acc, out_load, unit_done;

  assign in_stall  = (state_r != tds_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign fs_eff    = (fs_r == '0) ? 16'd1 : fs_r;
  assign unit_done = mul_done || div_done || ring_done;
  assign out_load  = (state_r == tds_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  assign tdiff = $signed({temp_r[14], temp_r}) - 16'sd2500;
  assign tneg  = -tdiff;
  assign tabs  = tdiff[15] ? tneg[14:0] : tdiff[14:0];

  assign prod64  = $signed(mul_prod[63:0]);
  assign acc_sum = acc_r + prod64;
  assign qx      = {2'b00, mul_prod[61:37]};
  assign comp_s  = neg_r ? (27'sd65536 - $signed(qx)) : (27'sd65536 + $signed(qx));
  assign comp_nxt = (comp_s < 27'sd1) ? 26'd1 : comp_s[25:0];
  assign rc_big   = |mul_prod[72:63];
  assign raw_big  = |mul_prod[86:56];
  assign cal_fail = (poly_r == '0) || (f_r == '0);

  assign out_valid          = out_valid_r;
  assign out_tds_centippm   = out_tds_r;
  assign out_probe_gain_q16 = out_gain_r;
  assign out_status         = out_status_r;

  tds_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  tds_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  tds_ring u_ring (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ring_req),
    .done (ring_done),
    .mean (ring_mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mul_req       = '0;
    div_req       = '0;
    ring_req.valid = 1'b0;
    ring_req.data  = raw_r;
    unique case (state_r)
      tds_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_command == tds_pkg::CMD_MEASURE || in_command == tds_pkg::CMD_CAL) begin
            state_nxt = tds_pkg::ST_NUM;
          end else begin
            state_nxt = tds_pkg::ST_FIN;
          end
        end
      end
      tds_pkg::ST_NUM: begin
        mul_req = '{!wait_r, {51'b0, ref_r}, {20'b0, code_r}};
        if (mul_done) state_nxt = tds_pkg::ST_DEN;
      end
      tds_pkg::ST_DEN: begin
        mul_req = '{!wait_r, {48'b0, fs_eff}, tds_pkg::MV_PER_V};
        if (mul_done) state_nxt = tds_pkg::ST_V;
      end
      tds_pkg::ST_V: begin
        div_req = '{!wait_r, {23'b0, num_r, 16'b0}, {15'b0, den_r}};
        if (div_done) state_nxt = tds_pkg::ST_V2;
      end
      tds_pkg::ST_V2: begin
        mul_req = '{!wait_r, {43'b0, v_r}, {11'b0, v_r}};
        if (mul_done) state_nxt = tds_pkg::ST_V3;
      end
      tds_pkg::ST_V3: begin
        mul_req = '{!wait_r, {38'b0, v2_r}, {11'b0, v_r}};
        if (mul_done) state_nxt = tds_pkg::ST_T3;
      end
      tds_pkg::ST_T3: begin
        mul_req = '{!wait_r, {33'b0, v3_r}, tds_pkg::COEF3};
        if (mul_done) state_nxt = tds_pkg::ST_T2;
      end
      tds_pkg::ST_T2: begin
        mul_req = '{!wait_r, {38'b0, v2_r}, tds_pkg::COEF2};
        if (mul_done) state_nxt = tds_pkg::ST_T1;
      end
      tds_pkg::ST_T1: begin
        mul_req = '{!wait_r, {43'b0, v_r}, tds_pkg::COEF1};
        if (mul_done) state_nxt = tds_pkg::ST_KD;
      end
      tds_pkg::ST_KD: begin
        mul_req = '{!wait_r, {48'b0, k_r}, {17'b0, tabs}};
        if (mul_done) state_nxt = tds_pkg::ST_C;
      end
      tds_pkg::ST_C: begin
        mul_req = '{!wait_r, {33'b0, kd_r}, tds_pkg::CENTI_RECIP};
        if (mul_done) begin
          if (cmd_r == tds_pkg::CMD_MEASURE) begin
            state_nxt = tds_pkg::ST_EC;
          end else if (cal_fail) begin
            state_nxt = tds_pkg::ST_FIN;
          end else begin
            state_nxt = tds_pkg::ST_RAWEC;
          end
        end
      end
      tds_pkg::ST_EC: begin
        mul_req = '{!wait_r, {24'b0, poly_r}, {8'b0, gain_r}};
        if (mul_done) state_nxt = tds_pkg::ST_ECC;
      end
      tds_pkg::ST_ECC: begin
        div_req = '{!wait_r, {ec_r, 16'b0}, {15'b0, comp_r}};
        if (div_done) state_nxt = tds_pkg::ST_FB;
      end
      tds_pkg::ST_FB: begin
        mul_req = '{!wait_r, {48'b0, f_r}, tds_pkg::CENTI};
        if (mul_done) state_nxt = tds_pkg::ST_RAW;
      end
      tds_pkg::ST_RAW: begin
        mul_req = '{!wait_r, ecc_r, {9'b0, fb_r}};
        if (mul_done) state_nxt = filt_r ? tds_pkg::ST_RING : tds_pkg::ST_FIN;
      end
      tds_pkg::ST_RING: begin
        ring_req.valid = !wait_r;
        if (ring_done) state_nxt = tds_pkg::ST_FIN;
      end
      tds_pkg::ST_RAWEC: begin
        div_req = '{!wait_r, {17'b0, ppm_r, 32'b0}, {25'b0, f_r}};
        if (div_done) state_nxt = tds_pkg::ST_RC;
      end
      tds_pkg::ST_RC: begin
        mul_req = '{!wait_r, {17'b0, rawec_r}, {6'b0, comp_r}};
        if (mul_done) state_nxt = rc_big ? tds_pkg::ST_FIN : tds_pkg::ST_G;
      end
      tds_pkg::ST_G: begin
        div_req = '{!wait_r, {1'b0, rc_r, 16'b0}, {1'b0, poly_r}};
        if (div_done) state_nxt = tds_pkg::ST_FIN;
      end
      tds_pkg::ST_FIN: begin
        if (out_load) state_nxt = tds_pkg::ST_IDLE;
      end
      default: state_nxt = tds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= tds_pkg::RST_REF_MV;
      fs_r        <= tds_pkg::RST_FS;
      f_r         <= tds_pkg::RST_TDS_F;
      k_r         <= tds_pkg::RST_TEMP_K;
      filt_r      <= 1'b0;
      gain_r      <= tds_pkg::GAIN_RESET;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tds_pkg::REG_REF_MV:  ref_r  <= cfg_data[12:0];
          tds_pkg::REG_FS:      fs_r   <= cfg_data;
          tds_pkg::REG_TDS_F:   f_r    <= cfg_data;
          tds_pkg::REG_TEMP_K:  k_r    <= cfg_data;
          tds_pkg::REG_FILT_EN: filt_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (mul_req.start || div_req.start || ring_req.valid) begin
        wait_r <= 1'b1;
      end else if (unit_done) begin
        wait_r <= 1'b0;
      end
      if (in_acc && in_command == tds_pkg::CMD_RESET) begin
        gain_r <= tds_pkg::GAIN_RESET;
      end else if (state_r == tds_pkg::ST_RC && mul_done && rc_big) begin
        gain_r <= tds_pkg::OUT_MAX;
      end else if (state_r == tds_pkg::ST_G && div_done) begin
        gain_r <= (div_q[63:24] != '0) ? tds_pkg::OUT_MAX : div_q[23:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= tds_pkg::cmd_t'(in_command);
      code_r   <= in_adc_sample;
      temp_r   <= in_temperature_centideg;
      ppm_r    <= in_reference_ppm;
      raw_r    <= '0;
      status_r <= (in_command == tds_pkg::CMD_RESET) ? tds_pkg::STS_GAIN_RESET
                                                     : tds_pkg::STS_CAL_FAIL;
    end
    if (out_load) begin
      out_tds_r    <= raw_r;
      out_gain_r   <= gain_r;
      out_status_r <= status_r;
    end
    unique case (state_r)
      tds_pkg::ST_NUM:   if (mul_done) num_r <= mul_prod[24:0];
      tds_pkg::ST_DEN:   if (mul_done) den_r <= mul_prod[25:0];
      tds_pkg::ST_V:     if (div_done) v_r <= (div_q > 64'(tds_pkg::V_MAX)) ? tds_pkg::V_MAX
                                                                               : div_q[20:0];
      tds_pkg::ST_V2:    if (mul_done) v2_r <= mul_prod[41:16];
      tds_pkg::ST_V3:    if (mul_done) v3_r <= mul_prod[46:16];
      tds_pkg::ST_T3:    if (mul_done) acc_r <= prod64;
      tds_pkg::ST_T2:    if (mul_done) acc_r <= acc_r - prod64;
      tds_pkg::ST_T1:    if (mul_done) poly_r <= acc_sum[63] ? 40'd0 : acc_sum[55:16];
      tds_pkg::ST_KD:    if (mul_done) begin
        kd_r  <= mul_prod[30:0];
        neg_r <= tdiff[15];
      end
      tds_pkg::ST_C:     if (mul_done) begin
        comp_r <= comp_nxt;
        if (cmd_r == tds_pkg::CMD_CAL && cal_fail) status_r <= tds_pkg::STS_CAL_FAIL;
      end
      tds_pkg::ST_EC:    if (mul_done) ec_r <= mul_prod[63:16];
      tds_pkg::ST_ECC:   if (div_done) ecc_r <= div_q;
      tds_pkg::ST_FB:    if (mul_done) fb_r <= mul_prod[22:0];
      tds_pkg::ST_RAW:   if (mul_done) begin
        raw_r    <= raw_big ? tds_pkg::OUT_MAX : mul_prod[55:32];
        status_r <= raw_big ? tds_pkg::STS_SATURATED : tds_pkg::STS_MEASURED;
      end
      tds_pkg::ST_RING:  if (ring_done) raw_r <= ring_mean;
      tds_pkg::ST_RAWEC: if (div_done) rawec_r <= div_q[46:0];
      tds_pkg::ST_RC:    if (mul_done) begin
        rc_r <= mul_prod[62:16];
        if (rc_big) status_r <= tds_pkg::STS_CALIBRATED;
      end
      tds_pkg::ST_G:     if (div_done) status_r <= tds_pkg::STS_CALIBRATED;
      default: ;
    endcase
  end

  `TDS_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_r != tds_pkg::ST_IDLE, "item accepted but sequencer idle")
  `TDS_ASSERT_IMP(a_mul_waited, mul_done, wait_r, "multiplier done without a pending request")
  `TDS_ASSERT_IMP(a_ring_state, ring_done, state_r == tds_pkg::ST_RING, "ring done outside ring step")
  `TDS_ASSERT_IMP(a_gain_reset, (state_r == tds_pkg::ST_FIN) && (cmd_r == tds_pkg::CMD_RESET), gain_r == tds_pkg::GAIN_RESET, "gain not restored by reset command")

endmodule

>>> rtl/core/tds_mul.sv
// ----------------------------------------------------------------------------
// TDS shift-add multiplier
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tds_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tds_pkg::mul_req_t           req,
  output logic                        done,
  output logic [tds_pkg::MUL_P_W-1:0] prod
);

  logic                        busy_r;
  logic [tds_pkg::MUL_P_W-1:0] a_r;
  logic [tds_pkg::MUL_B_W-1:0] b_r;
  logic [tds_pkg::MUL_P_W-1:0] acc_r;

  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= {{(tds_pkg::MUL_P_W-tds_pkg::MUL_A_W){1'b0}}, req.a};
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r && !done) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

endmodule

>>> rtl/core/tds_div.sv
// ----------------------------------------------------------------------------
// TDS restoring divider
// Unsigned divider, one quotient bit per cycle, fixed step count.
// ----------------------------------------------------------------------------
module tds_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tds_pkg::div_req_t             req,
  output logic                          done,
  output logic [tds_pkg::DIV_NUM_W-1:0] quot
);

  logic [tds_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          done_r;
  logic [tds_pkg::DIV_NUM_W-1:0] num_r;
  logic [tds_pkg::DIV_DEN_W-1:0] den_r;
  logic [tds_pkg::DIV_DEN_W-1:0] rem_r;
  logic [tds_pkg::DIV_DEN_W:0]   rem_sh;
  logic [tds_pkg::DIV_DEN_W+1:0] diff;

  assign rem_sh = {rem_r, num_r[tds_pkg::DIV_NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign done   = done_r;
  assign quot   = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == tds_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        cnt_r <= tds_pkg::DIV_CNT_W'(tds_pkg::DIV_NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      if (!diff[tds_pkg::DIV_DEN_W+1]) begin
        rem_r <= diff[tds_pkg::DIV_DEN_W-1:0];
        num_r <= {num_r[tds_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[tds_pkg::DIV_DEN_W-1:0];
        num_r <= {num_r[tds_pkg::DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/core/tds_ring.sv
// ----------------------------------------------------------------------------
// TDS history ring
// History memory with running sum; read old entry, write new, give the mean.
// ----------------------------------------------------------------------------
module tds_ring (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tds_pkg::ring_req_t        req,
  output logic                      done,
  output logic [tds_pkg::OUT_W-1:0] mean
);

  logic [tds_pkg::OUT_W-1:0] mem [tds_pkg::FILTER_DEPTH];
  logic [tds_pkg::FILTER_DEPTH-1:0] vld_r;
  logic [tds_pkg::PTR_W-1:0] ptr_r;
  logic [tds_pkg::PTR_W-1:0] ptr_nxt;
  logic [tds_pkg::SUM_W-1:0] sum_r;
  logic [tds_pkg::SUM_W-1:0] sum_nxt;
  logic [tds_pkg::OUT_W-1:0] rd_data_r;
  logic [tds_pkg::OUT_W-1:0] data_r;
  logic [tds_pkg::OUT_W-1:0] old;
  logic                      pend_r;
  logic                      done_r;
  logic [tds_pkg::OUT_W-1:0] mean_r;

  assign old     = vld_r[ptr_r] ? rd_data_r : '0;
  assign sum_nxt = sum_r - tds_pkg::SUM_W'(old) + tds_pkg::SUM_W'(data_r);
  assign ptr_nxt = (ptr_r == tds_pkg::PTR_W'(tds_pkg::FILTER_DEPTH - 1)) ? '0
                                                                          : ptr_r + 1'b1;
  assign done    = done_r;
  assign mean    = mean_r;

  always_ff @(posedge clk) begin
    if (pend_r) begin
      mem[ptr_r] <= data_r;
    end
    rd_data_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ptr_r  <= '0;
      sum_r  <= '0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pend_r <= req.valid;
      done_r <= pend_r;
      if (pend_r) begin
        vld_r[ptr_r] <= 1'b1;
        ptr_r        <= ptr_nxt;
        sum_r        <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      data_r <= req.data;
    end
    if (pend_r) begin
      mean_r <= tds_pkg::OUT_W'(sum_nxt / tds_pkg::SUM_W'(tds_pkg::FILTER_DEPTH));
    end
  end

endmodule
